// ===== rtl/mspp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mspp_pkg;

    // field widths
    localparam int GAIN_W   = 24;
    localparam int SPEED_W  = 15;
    localparam int RPM_W    = 16;
    localparam int DUTY_W   = 15;
    localparam int ERR_W    = 18;
    localparam int DERIV_W  = 19;
    localparam int SPAN_W   = 17;
    localparam int PID_W    = 48;
    localparam int QUO_W    = 16;
    localparam int CFG_IDX_W = 3;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KP        = 3'd0,
        CFG_KI        = 3'd1,
        CFG_KD        = 3'd2,
        CFG_SPD_LIMIT = 3'd3,
        CFG_SPD_BASE  = 3'd4,
        CFG_DUTY_MAX  = 3'd5,
        CFG_INVERT    = 3'd6
    } cfg_idx_t;

    // product phases
    typedef enum logic [1:0] {
        PH_P = 2'd0,
        PH_D = 2'd1,
        PH_I = 2'd2
    } phase_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL,
        ST_SAT,
        ST_PREP,
        ST_SCALE,
        ST_DIVPREP,
        ST_OVF,
        ST_DIV,
        ST_FIN
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/motor_speed_pid_pwm.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Speed PID with sign-magnitude PWM output, one wheel per instance. Each input
// beat carries a setpoint and a measured speed in RPM; the block clamps the
// measured speed to +- the speed limit, updates a saturating integral and the
// previous error, forms pid = e*kp + integral*ki + (e - prev)*kd in
// Q.GAIN_FRAC_BITS saturated to 48 bits, scales it by
// duty_max / (speed limit - span base), saturates to +-duty_max, optionally
// negates it and returns one result beat with the PID sum, the PWM compare
// value and the reverse bit. A zero span gives full duty for a nonzero PID
// sum. The datapath is bit serial: the three gain products go through one
// shift-add accumulator at one gain bit per cycle, the duty scaling is a
// shift-add over the duty_max bits and the quotient comes from an overflow
// check state and a 16-bit restoring divider, both skipped with a zero
// span. The next input beat is taken only once the previous result has
// gone into the output register. Registers are written through
// cfg_we/cfg_addr/cfg_wdata only while the block is idle: the user must
// keep to this, as the block itself does not enforce it.
module motor_speed_pid_pwm
    import mspp_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = 16,
    parameter int INTEGRAL_WIDTH = 32
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,

    // configuration write port
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_addr,
    input  wire logic [GAIN_W-1:0]    cfg_wdata,

    // input stream
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [31:0]          s_tdata,  // setpoint_rpm[15:0], measured_rpm[31:16]

    // result stream
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [63:0]               m_tdata   // pid_output[47:0], compare_value[62:48],
                                                // reverse[63]
);

    // exact sum of all three products
    localparam int SUM_W = (INTEGRAL_WIDTH + 26 > PID_W) ? INTEGRAL_WIDTH + 26 : PID_W;
    // accumulator and multiplicand also hold |pid| * duty_max
    localparam int ACC_W = (SUM_W > PID_W + DUTY_W) ? SUM_W : PID_W + DUTY_W;
    // divisor is |span| scaled to Q.GAIN_FRAC_BITS
    localparam int DEN_W = SPAN_W + GAIN_FRAC_BITS;
    localparam int DIV_W = (DEN_W + QUO_W + 1 > 64) ? DEN_W + QUO_W + 1 : 64;
    localparam int IW    = INTEGRAL_WIDTH;

    // configuration registers
    logic signed [GAIN_W-1:0]  kp_reg, ki_reg, kd_reg;
    logic [SPEED_W-1:0]        spd_limit_reg;
    logic signed [RPM_W-1:0]   spd_base_reg;
    logic [DUTY_W-1:0]         duty_max_reg;
    logic                      invert_reg;

    // controller state
    logic signed [IW-1:0]      integ_reg, integ_next;
    logic signed [ERR_W-1:0]   prev_reg, prev_next;
    logic signed [ERR_W-1:0]   err_reg, err_next;
    logic signed [DERIV_W-1:0] deriv_reg, deriv_next;

    // sequencer
    state_t                    state_reg, state_next;
    phase_t                    phase_reg, phase_next;
    logic [4:0]                cnt_reg, cnt_next;

    // serial datapath
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic [ACC_W-1:0]          mcand_reg, mcand_next;
    logic [GAIN_W-1:0]         mplier_reg, mplier_next;
    logic signed [PID_W-1:0]   pid_reg, pid_next;
    logic [DIV_W-1:0]          num_reg, num_next;
    logic [DIV_W-1:0]          dsh_reg, dsh_next;
    logic [QUO_W-1:0]          quo_reg, quo_next;
    logic                      ovf_reg, ovf_next;

    // output register
    logic                      m_valid_reg, m_valid_next;
    logic [63:0]               m_data_reg, m_data_next;

    // ---------------------------------------------------------------------
    // configuration writes
    // ---------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_reg        <= '0;
            ki_reg        <= '0;
            kd_reg        <= '0;
            spd_limit_reg <= '0;
            spd_base_reg  <= '0;
            duty_max_reg  <= '0;
            invert_reg    <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_KP:        kp_reg        <= cfg_wdata;
                CFG_KI:        ki_reg        <= cfg_wdata;
                CFG_KD:        kd_reg        <= cfg_wdata;
                CFG_SPD_LIMIT: spd_limit_reg <= cfg_wdata[SPEED_W-1:0];
                CFG_SPD_BASE:  spd_base_reg  <= cfg_wdata[RPM_W-1:0];
                CFG_DUTY_MAX:  duty_max_reg  <= cfg_wdata[DUTY_W-1:0];
                CFG_INVERT:    invert_reg    <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // input side: error, derivative and integral update at the input beat
    // ---------------------------------------------------------------------
    logic                     s_fire;
    logic signed [16:0]       meas17, max17, clamp17;
    logic signed [ERR_W-1:0]  err_in;
    logic signed [IW:0]       integ_sum;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;

    always_comb begin
        meas17 = 17'(signed'(s_tdata[31:16]));
        max17  = signed'({2'b00, spd_limit_reg});
        if (meas17 > max17) begin
            clamp17 = max17;
        end else if (meas17 < -max17) begin
            clamp17 = -max17;
        end else begin
            clamp17 = meas17;
        end
        err_in    = ERR_W'(signed'(s_tdata[15:0])) - ERR_W'(clamp17);
        integ_sum = (IW+1)'(integ_reg) + (IW+1)'(err_in);
    end

    // span and its magnitude for the scaling divide
    logic signed [SPAN_W-1:0] span;
    logic [SPAN_W-1:0]        span_mag;
    logic                     span_zero, span_neg;

    always_comb begin
        span      = SPAN_W'(signed'({1'b0, spd_limit_reg})) - SPAN_W'(spd_base_reg);
        span_neg  = span[SPAN_W-1];
        span_mag  = span_neg ? SPAN_W'(-span) : SPAN_W'(span);
        span_zero = (span == '0);
    end

    // ---------------------------------------------------------------------
    // next state
    // ---------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (s_fire) state_next = ST_LOAD;
            ST_LOAD:    state_next = ST_MUL;
            ST_MUL: begin
                if (cnt_reg == 5'(GAIN_W - 1)) begin
                    state_next = (phase_reg == PH_I) ? ST_SAT : ST_LOAD;
                end
            end
            ST_SAT:     state_next = ST_PREP;
            ST_PREP:    state_next = ST_SCALE;
            ST_SCALE:   if (cnt_reg == 5'(DUTY_W - 1)) state_next = ST_DIVPREP;
            ST_DIVPREP: state_next = span_zero ? ST_FIN : ST_OVF;
            ST_OVF:     state_next = ST_DIV;
            ST_DIV:     if (cnt_reg == 5'(QUO_W - 1)) state_next = ST_FIN;
            ST_FIN:     if (!m_valid_reg || m_tready) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------------
    // datapath next values
    // ---------------------------------------------------------------------
    logic [ACC_W-1:0]      addend;
    logic                  pid_neg;
    logic [PID_W-1:0]      pid_mag;
    logic                  pid_fits;
    logic [QUO_W-1:0]      q_sat;
    logic                  duty_neg, duty_nz;
    logic [DUTY_W-1:0]     cmp_val;

    always_comb begin
        integ_next   = integ_reg;
        prev_next    = prev_reg;
        err_next     = err_reg;
        deriv_next   = deriv_reg;
        phase_next   = phase_reg;
        cnt_next     = cnt_reg;
        acc_next     = acc_reg;
        mcand_next   = mcand_reg;
        mplier_next  = mplier_reg;
        pid_next     = pid_reg;
        num_next     = num_reg;
        dsh_next     = dsh_reg;
        quo_next     = quo_reg;
        ovf_next     = ovf_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        addend   = '0;
        pid_neg  = pid_reg[PID_W-1];
        pid_mag  = pid_neg ? PID_W'(-pid_reg) : PID_W'(pid_reg);
        pid_fits = (acc_reg[ACC_W-1:PID_W-1] == '0) || (acc_reg[ACC_W-1:PID_W-1] == '1);

        // duty magnitude and sign
        if (span_zero) begin
            q_sat    = (pid_reg != '0) ? QUO_W'(duty_max_reg) : '0;
            duty_neg = pid_neg;
        end else begin
            q_sat    = (ovf_reg || quo_reg > QUO_W'(duty_max_reg)) ?
                       QUO_W'(duty_max_reg) : quo_reg;
            duty_neg = pid_neg ^ span_neg;
        end
        duty_neg = duty_neg ^ invert_reg;
        duty_nz  = (q_sat != '0);
        if (!duty_nz) begin
            cmp_val = '0;
        end else if (duty_neg) begin
            cmp_val = duty_max_reg - DUTY_W'(q_sat);
        end else begin
            cmp_val = DUTY_W'(q_sat);
        end

        if (m_valid_reg && m_tready) m_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    err_next   = err_in;
                    deriv_next = DERIV_W'(err_in) - DERIV_W'(prev_reg);
                    prev_next  = err_in;
                    if (integ_sum[IW] != integ_sum[IW-1]) begin
                        integ_next = integ_sum[IW] ? {1'b1, {(IW-1){1'b0}}}
                                                   : {1'b0, {(IW-1){1'b1}}};
                    end else begin
                        integ_next = integ_sum[IW-1:0];
                    end
                    phase_next = PH_P;
                    acc_next   = '0;
                end
            end
            ST_LOAD: begin
                cnt_next = '0;
                case (phase_reg)
                    PH_P: begin
                        mcand_next  = ACC_W'(err_reg);
                        mplier_next = kp_reg;
                    end
                    PH_D: begin
                        mcand_next  = ACC_W'(deriv_reg);
                        mplier_next = kd_reg;
                    end
                    default: begin
                        mcand_next  = ACC_W'(integ_reg);
                        mplier_next = ki_reg;
                    end
                endcase
            end
            ST_MUL: begin
                // top gain bit carries negative weight
                if (mplier_reg[0]) begin
                    addend = (cnt_reg == 5'(GAIN_W - 1)) ? -mcand_reg : mcand_reg;
                end
                acc_next    = acc_reg + signed'(addend);
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                cnt_next    = cnt_reg + 5'd1;
                if (cnt_reg == 5'(GAIN_W - 1)) begin
                    case (phase_reg)
                        PH_P:    phase_next = PH_D;
                        PH_D:    phase_next = PH_I;
                        default: phase_next = PH_I;
                    endcase
                end
            end
            ST_SAT: begin
                if (pid_fits) begin
                    pid_next = acc_reg[PID_W-1:0];
                end else begin
                    pid_next = acc_reg[ACC_W-1] ? {1'b1, {(PID_W-1){1'b0}}}
                                                : {1'b0, {(PID_W-1){1'b1}}};
                end
            end
            ST_PREP: begin
                mcand_next  = ACC_W'(pid_mag);
                mplier_next = GAIN_W'(duty_max_reg);
                num_next    = '0;
                cnt_next    = '0;
            end
            ST_SCALE: begin
                if (mplier_reg[0]) num_next = num_reg + DIV_W'(mcand_reg);
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                cnt_next    = cnt_reg + 5'd1;
            end
            ST_DIVPREP: begin
                dsh_next = DIV_W'(span_mag) << (GAIN_FRAC_BITS + QUO_W);
                quo_next = '0;
                ovf_next = 1'b0;
                cnt_next = '0;
            end
            ST_OVF: begin
                // quotient too big for the divider width: saturates anyway
                ovf_next = (num_reg >= dsh_reg);
                dsh_next = dsh_reg >> 1;
            end
            ST_DIV: begin
                if (num_reg >= dsh_reg) begin
                    num_next = num_reg - dsh_reg;
                    quo_next = {quo_reg[QUO_W-2:0], 1'b1};
                end else begin
                    quo_next = {quo_reg[QUO_W-2:0], 1'b0};
                end
                dsh_next = dsh_reg >> 1;
                cnt_next = cnt_reg + 5'd1;
            end
            ST_FIN: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {duty_nz & duty_neg, cmp_val, pid_reg};
                end
            end
            default: ;
        endcase
    end

    // ---------------------------------------------------------------------
    // registers
    // ---------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            phase_reg   <= PH_P;
            cnt_reg     <= '0;
            integ_reg   <= '0;
            prev_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            cnt_reg     <= cnt_next;
            integ_reg   <= integ_next;
            prev_reg    <= prev_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        err_reg    <= err_next;
        deriv_reg  <= deriv_next;
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        pid_reg    <= pid_next;
        num_reg    <= num_next;
        dsh_reg    <= dsh_next;
        quo_reg    <= quo_next;
        ovf_reg    <= ovf_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

`default_nettype wire

// ===== dv/motor_speed_pid_pwm_test.sv =====
`timescale 1ns / 1ps

module motor_speed_pid_pwm_test;
    import mspp_pkg::*;

    localparam int GFB       = 16;
    localparam int INT_W     = 32;
    localparam int WDOG_MAX  = 20000;
    localparam int RAND_BEATS = 1250;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_addr;
    logic [GAIN_W-1:0]    cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [31:0]          s_tdata;   // setpoint_rpm[15:0], measured_rpm[31:16]
    logic                 m_tvalid;
    logic                 m_tready;
    logic [63:0]          m_tdata;   // pid_output[47:0], compare_value[62:48], reverse[63]

    motor_speed_pid_pwm uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // clock, 8 ns period
    always begin
        aclk = 1'b0; #4;
        aclk = 1'b1; #4;
    end

    // one expected result beat
    typedef struct packed {
        logic [47:0] pid;
        logic [14:0] cmp;
        logic        rev;
    } speed_cmd_t;

    speed_cmd_t cmd_queue[$];

    // shadow of the control registers and loop state
    longint gain_p, gain_i, gain_d;
    longint speed_hi, speed_lo, duty_full;
    bit     flip_dir;
    longint err_sum, err_prev;

    int errors;
    int idle_cycles;
    int snd_idle_pct, rcv_idle_pct;
    bit timed_out;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t: %s got %0d want %0d", $realtime, what, got, want);
        errors++;
    endtask

    function automatic longint sat(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint absval(input longint v);
        return v < 0 ? -v : v;
    endfunction

    // integral product clamped to 2^60; the block itself sums the exact product
    function automatic longint clamped_product(input longint a, input longint b);
        longint ma, mb, m;
        ma = absval(a);
        mb = absval(b);
        if (ma == 0 || mb == 0) return 0;
        if (ma > (longint'(1) <<< 60) / mb) m = longint'(1) <<< 60;
        else m = ma * mb;
        return ((a < 0) != (b < 0)) ? -m : m;
    endfunction

    // control tick: updates loop state and returns the expected command
    function automatic speed_cmd_t speed_tick(input logic [15:0] sp_raw,
                                              input logic [15:0] ms_raw);
        speed_cmd_t r;
        longint sp, ms, e, d, pid, span, duty, q;
        logic [127:0] num;
        sp = longint'($signed(sp_raw));
        ms = sat(longint'($signed(ms_raw)), -speed_hi, speed_hi);
        e = sp - ms;
        err_sum = sat(err_sum + e, -(longint'(1) <<< (INT_W-1)),
                      (longint'(1) <<< (INT_W-1)) - 1);
        d = e - err_prev;
        err_prev = e;
        pid = e * gain_p + d * gain_d + clamped_product(err_sum, gain_i);
        pid = sat(pid, -(longint'(1) <<< 47), (longint'(1) <<< 47) - 1);
        span = speed_hi - speed_lo;
        if (span == 0) begin
            duty = pid > 0 ? duty_full : (pid < 0 ? -duty_full : 0);
        end else begin
            num = 128'(absval(pid)) * 128'(duty_full);
            q = longint'(num / (128'(absval(span)) << GFB));
            if (q > duty_full) q = duty_full;
            duty = ((pid < 0) != (span < 0)) ? -q : q;
        end
        if (flip_dir) duty = -duty;
        r.pid = pid[47:0];
        r.cmp = '0;
        r.rev = 1'b0;
        if (duty > 0) begin
            r.cmp = 15'(duty);
        end else if (duty < 0) begin
            r.cmp = 15'(duty_full + duty);
            r.rev = 1'b1;
        end
        return r;
    endfunction

    // register write, only while idle; the caller drops cfg_we afterwards
    task automatic write_reg(input cfg_idx_t idx, input logic [23:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            CFG_KP:        gain_p    = longint'($signed(val));
            CFG_KI:        gain_i    = longint'($signed(val));
            CFG_KD:        gain_d    = longint'($signed(val));
            CFG_SPD_LIMIT: speed_hi  = longint'(val[14:0]);
            CFG_SPD_BASE:  speed_lo  = longint'($signed(val[15:0]));
            CFG_DUTY_MAX:  duty_full = longint'(val[14:0]);
            CFG_INVERT:    flip_dir  = val[0];
            default: ;
        endcase
    endtask

    task automatic load_gains(input logic [23:0] p, input logic [23:0] i,
                              input logic [23:0] d, input logic [14:0] hi,
                              input logic [15:0] lo, input logic [14:0] dm,
                              input bit inv);
        write_reg(CFG_KP, p);
        write_reg(CFG_KI, i);
        write_reg(CFG_KD, d);
        write_reg(CFG_SPD_LIMIT, 24'(hi));
        write_reg(CFG_SPD_BASE, 24'(lo));
        write_reg(CFG_DUTY_MAX, 24'(dm));
        write_reg(CFG_INVERT, 24'(inv));
        cfg_we <= 1'b0;
    endtask

    // send one beat; optional idle before it, valid stays up between beats without idle
    task automatic send_tick(input logic [15:0] sp, input logic [15:0] ms,
                             input bit has_want, input speed_cmd_t want);
        speed_cmd_t exp_cmd;
        while ($urandom_range(99) < snd_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {ms, sp};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        exp_cmd = speed_tick(sp, ms);
        // typed-in value must agree with the predictor too
        if (has_want && exp_cmd != want)
            report_mismatch("directed table", longint'(exp_cmd), longint'(want));
        cmd_queue.push_back(has_want ? want : exp_cmd);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (cmd_queue.size() != 0 && !timed_out) @(posedge aclk);
        repeat (130) @(posedge aclk);
    endtask

    // receiver: random stall and compare
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (cmd_queue.size() == 0) begin
                    report_mismatch("unexpected beat", longint'(m_tdata[47:0]), 0);
                end else begin
                    speed_cmd_t w;
                    w = cmd_queue.pop_front();
                    if (m_tdata[47:0] != w.pid)
                        report_mismatch("pid_output", longint'($signed(m_tdata[47:0])),
                                        longint'($signed(w.pid)));
                    if (m_tdata[62:48] != w.cmp)
                        report_mismatch("compare_value", m_tdata[62:48], w.cmp);
                    if (m_tdata[63] != w.rev)
                        report_mismatch("reverse", m_tdata[63], w.rev);
                end
            end
            m_tready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    // watchdog on cycles without any accepted beat
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX && !timed_out) begin
            timed_out = 1'b1;
            $display("motor_speed_pid_pwm: mismatch");
            $finish;
        end
    end

    // directed table
    typedef struct {
        logic [15:0] sp;
        logic [15:0] ms;
        bit          has_want;
        speed_cmd_t  want;
    } tick_row_t;

    tick_row_t dir_rows[$];

    task automatic run_phase(input int n);
        for (int k = 0; k < n; k++) begin
            logic [15:0] sp, ms;
            case ($urandom_range(3))
                0: sp = 16'($urandom);
                1: sp = 16'($signed(16'($urandom_range(400))) - 16'sd200);
                2: sp = $urandom_range(1) ? 16'h7fff : 16'h8000;
                default: sp = 16'($urandom_range(3000));
            endcase
            ms = ($urandom_range(3) == 0) ? 16'($urandom)
                                          : 16'(sp + 16'($urandom_range(64)) - 16'd32);
            send_tick(sp, ms, 1'b0, '0);
        end
    endtask

    task automatic random_gains;
        load_gains(24'($urandom_range(1) ? $urandom : $urandom_range(2048)),
                   24'($urandom_range(1) ? $urandom : $urandom_range(256)),
                   24'($urandom),
                   15'($urandom_range(3) == 0 ? $urandom : $urandom_range(6000)),
                   16'($urandom_range(3) == 0 ? $urandom : $urandom_range(2000)),
                   15'($urandom),
                   $urandom_range(1));
    endtask

    initial begin
        errors = 0; idle_cycles = 0; timed_out = 0;
        snd_idle_pct = 0; rcv_idle_pct = 0;
        gain_p = 0; gain_i = 0; gain_d = 0;
        speed_hi = 0; speed_lo = 0; duty_full = 0; flip_dir = 0;
        err_sum = 0; err_prev = 0;
        aresetn <= 1'b0; cfg_we <= 1'b0; cfg_addr <= '0; cfg_wdata <= '0;
        s_tvalid <= 1'b0; s_tdata <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // after reset all gains are zero: zero pid, zero duty
        dir_rows.push_back('{16'd100, 16'd50, 1'b1, '{48'd0, 15'd0, 1'b0}});
        dir_rows.push_back('{16'h7fff, 16'h8000, 1'b1, '{48'd0, 15'd0, 1'b0}});
        foreach (dir_rows[r])
            send_tick(dir_rows[r].sp, dir_rows[r].ms, dir_rows[r].has_want,
                      dir_rows[r].want);
        drain();

        // zero span, kp = 1.0: sign of pid picks full duty
        load_gains(24'h010000, 24'h000000, 24'h000000, 15'd0, 16'd0, 15'd1000, 1'b0);
        dir_rows.delete();
        dir_rows.push_back('{16'd5, 16'd0, 1'b1, '{48'(5 <<< 16), 15'd1000, 1'b0}});
        dir_rows.push_back('{16'hfffb, 16'd0, 1'b1, '{48'(-(5 <<< 16)), 15'd0, 1'b1}});
        dir_rows.push_back('{16'd0, 16'd0, 1'b1, '{48'd0, 15'd0, 1'b0}});
        foreach (dir_rows[r])
            send_tick(dir_rows[r].sp, dir_rows[r].ms, dir_rows[r].has_want,
                      dir_rows[r].want);
        drain();

        // extreme gains and speed limits: clamp of measured speed
        load_gains(24'h7fffff, 24'h800000, 24'h7fffff, 15'h7fff, 16'h8000, 15'h7fff, 1'b0);
        for (int k = 0; k < 6; k++) send_tick(16'h7fff, 16'h8000, 1'b0, '0);
        for (int k = 0; k < 4; k++) send_tick(16'h8000, 16'h7fff, 1'b0, '0);
        drain();

        // negative span, inverted direction
        load_gains(24'h008000, 24'h000100, 24'hff8000, 15'd100, 16'd3000, 15'd500, 1'b1);
        send_tick(16'd200, 16'd150, 1'b0, '0);
        send_tick(16'hff00, 16'd400, 1'b0, '0);
        send_tick(16'd0, 16'd0, 1'b0, '0);
        drain();

        // random phases, three idling patterns
        for (int ph = 0; ph < 3; ph++) begin
            snd_idle_pct = (ph == 0) ? 13 : (ph == 1) ? 83 : 0;
            rcv_idle_pct = (ph == 0) ? 83 : (ph == 1) ? 13 : 0;
            for (int g = 0; g < 6; g++) begin
                random_gains();
                run_phase(RAND_BEATS / 18);
                drain();
            end
        end

        if (errors == 0 && cmd_queue.size() == 0)
            $display("motor_speed_pid_pwm: match");
        else
            $display("motor_speed_pid_pwm: mismatch");
        $finish;
    end

endmodule
